FILE: rtl/core/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the header decoder RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/mahd_pkg.sv
//------------------------------------------------------------------------------
// mahd_pkg
// Types, status codes and constant tables of the audio frame header decoder.
//------------------------------------------------------------------------------
package mahd_pkg;

    // Result status codes; the first failing check wins.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SYNC     = 3'd1,
        ST_RSV_VERSION = 3'd2,
        ST_RSV_LAYER   = 3'd3,
        ST_BAD_BITRATE = 3'd4,
        ST_BAD_RATE    = 3'd5,
        ST_LAYER_ONE   = 3'd6
    } t_status;

    // Version codes as reported on the result.
    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    // Layer field codes in the header (two bits).
    localparam logic [1:0] LBITS_RSV   = 2'b00;
    localparam logic [1:0] LBITS_LAYER3 = 2'b01;
    localparam logic [1:0] LBITS_LAYER1 = 2'b11;

    // Bitrate index and sampling-rate codes that are invalid.
    localparam logic [3:0] BRI_FREE = 4'h0;
    localparam logic [3:0] BRI_BAD  = 4'hF;
    localparam logic [1:0] SR_RSV   = 2'b11;

    // Bitrate tables in kbit/s, indexed by the bitrate index.
    localparam logic [8:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0
    };
    localparam logic [8:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [8:0] KBPS_LSF [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };

    // Frame bytes are kbps * 144000 / rate. For the MPEG1 rates this is
    // kbps * 1440 / 441, kbps * 6 / 2 and kbps * 9 / 2. Lower rates (and the
    // layer III halving) only scale the numerator by a power of two.
    localparam logic [10:0] RATE_SCALE [4] = '{11'd1440, 11'd6, 11'd9, 11'd0};

    // Reciprocal of 441 scaled by 2^29, rounded up. Exact for numerators
    // below 2^20, which covers every valid header.
    localparam int          Q441_SHIFT = 29;
    localparam logic [20:0] RECIP_441  = 21'd1217395;

    localparam int NUM_W  = 20;
    localparam int SIZE_W = 12;

    // Decoded header fields; all zero except status on a failed check.
    typedef struct packed {
        t_status    status;
        logic [1:0] version;
        logic [1:0] layer;
        logic       crc_present;
        logic [3:0] kbps_index;
        logic [3:0] sample_rate_index;
        logic       padding;
        logic [1:0] channel_mode;
        logic [1:0] mode_extension;
        logic [1:0] emphasis;
        logic [2:0] misc_flags;
    } t_fields;

    // Controls for the frame size datapath.
    typedef struct packed {
        logic [8:0] kbps;
        logic [1:0] rate_sel;
        logic [1:0] shift;
        logic       div441;
    } t_size_ctl;

    // One complete result item.
    typedef struct packed {
        t_fields           fields;
        logic [SIZE_W-1:0] frame_size;
    } t_result;

endpackage

FILE: rtl/core/mahd_in_if.sv
//------------------------------------------------------------------------------
// mahd_in_if
// Header word channel with valid/ready handshake.
//------------------------------------------------------------------------------
interface mahd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;

    modport source (output valid, output header_word, input ready);
    modport sink   (input valid, input header_word, output ready);
endinterface

FILE: rtl/core/mahd_out_if.sv
//------------------------------------------------------------------------------
// mahd_out_if
// Decoded header result channel with valid/ready handshake.
//------------------------------------------------------------------------------
interface mahd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic        crc_present;
    logic [3:0]  kbps_index;
    logic [3:0]  sample_rate_index;
    logic        padding;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  emphasis;
    logic [2:0]  misc_flags;
    logic [11:0] frame_size;

    modport source (
        output valid, input ready,
        output status, output version, output layer, output crc_present,
        output kbps_index, output sample_rate_index, output padding,
        output channel_mode, output mode_extension, output emphasis,
        output misc_flags, output frame_size
    );
    modport sink (
        input valid, output ready,
        input status, input version, input layer, input crc_present,
        input kbps_index, input sample_rate_index, input padding,
        input channel_mode, input mode_extension, input emphasis,
        input misc_flags, input frame_size
    );
endinterface

FILE: rtl/core/mahd_decode.sv
//------------------------------------------------------------------------------
// mahd_decode
// First pipeline stage: header checks, field unpacking and bitrate lookup.
//------------------------------------------------------------------------------
module mahd_decode
    import mahd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_word,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output t_fields     o_fields,
    output t_size_ctl   o_ctl
);

    logic       r_valid;
    t_fields    r_fields;
    t_size_ctl  r_ctl;
    t_fields    n_fields;
    t_size_ctl  n_ctl;

    logic       lsf;
    logic       layer3;
    logic [1:0] ver;
    logic [1:0] lbits;
    logic [1:0] sr;
    logic [3:0] bri;
    t_status    status;

    // Checks in header order, but the layer I check comes last; the first failure sets the status.
    always_comb begin
        lsf    = i_word[20] ? ~i_word[19] : 1'b1;
        ver    = i_word[20] ? {1'b0, ~i_word[19]} : VER_MPEG25;
        lbits  = i_word[18:17];
        bri    = i_word[15:12];
        sr     = i_word[11:10];
        layer3 = (lbits == LBITS_LAYER3);

        if (!(&i_word[31:21])) begin
            status = ST_NO_SYNC;
        end else if (!i_word[20] && i_word[19]) begin
            status = ST_RSV_VERSION;
        end else if (lbits == LBITS_RSV) begin
            status = ST_RSV_LAYER;
        end else if (bri == BRI_FREE || bri == BRI_BAD) begin
            status = ST_BAD_BITRATE;
        end else if (sr == SR_RSV) begin
            status = ST_BAD_RATE;
        end else if (lbits == LBITS_LAYER1) begin
            status = ST_LAYER_ONE;
        end else begin
            status = ST_OK;
        end
    end

    // Field unpacking; a failed header carries only its status.
    always_comb begin
        n_fields        = '0;
        n_fields.status = status;
        if (status == ST_OK) begin
            n_fields.version       = ver;
            n_fields.layer         = 2'(3'd4 - {1'b0, lbits});
            n_fields.crc_present   = ~i_word[16];
            n_fields.kbps_index    = bri;
            if (ver == VER_MPEG25) begin
                n_fields.sample_rate_index = 4'(4'd6 + {2'b00, sr});
            end else begin
                n_fields.sample_rate_index = 4'({2'b00, sr} + (lsf ? 4'd3 : 4'd0));
            end
            n_fields.padding        = i_word[9];
            n_fields.channel_mode   = i_word[7:6];
            n_fields.mode_extension = i_word[5:4];
            n_fields.emphasis       = i_word[1:0];
            n_fields.misc_flags     = {i_word[8], i_word[3], i_word[2]};
        end
    end

    // Bitrate lookup and rate scaling for the size datapath.
    always_comb begin
        if (lsf) begin
            n_ctl.kbps = KBPS_LSF[bri];
        end else if (layer3) begin
            n_ctl.kbps = KBPS_V1_L3[bri];
        end else begin
            n_ctl.kbps = KBPS_V1_L2[bri];
        end
        n_ctl.rate_sel = sr;
        n_ctl.shift    = ver - {1'b0, layer3 & lsf};
        n_ctl.div441   = (sr == 2'b00);
    end

    // Stage register with its own valid bit.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_fields <= n_fields;
            r_ctl    <= n_ctl;
        end
    end

    assign o_valid  = r_valid;
    assign o_fields = r_fields;
    assign o_ctl    = r_ctl;

endmodule

FILE: rtl/core/mahd_size.sv
//------------------------------------------------------------------------------
// mahd_size
// Stages two to four: numerator multiply, constant division, padding add.
//------------------------------------------------------------------------------
module mahd_size
    import mahd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_fields   i_fields,
    input  t_size_ctl i_ctl,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_result
);

    localparam int PROD_W = NUM_W + 21;

    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    t_fields           r_f2;
    t_fields           r_f3;
    t_fields           r_f4;
    logic [NUM_W-1:0]  r_x2;
    logic              r_div2;
    logic [SIZE_W-1:0] r_q3;
    logic [SIZE_W-1:0] r_size4;

    logic [NUM_W-1:0]  n_x2;
    logic [SIZE_W-1:0] n_q3;
    logic [SIZE_W-1:0] n_size4;
    logic [21:0]       num_prod;
    logic [PROD_W-1:0] recip_prod;
    logic              rdy2;
    logic              rdy3;
    logic              rdy4;

    // Each stage loads when it is empty or its contents move on.
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // Stage two: numerator kbps times the rate scale, times a power of two.
    always_comb begin
        num_prod = 22'(i_ctl.kbps) * 22'(RATE_SCALE[i_ctl.rate_sel]);
        n_x2     = NUM_W'(num_prod << i_ctl.shift);
    end

    // Stage three: divide by 441 through the reciprocal, or halve.
    always_comb begin
        recip_prod = PROD_W'(r_x2) * PROD_W'(RECIP_441);
        if (r_div2) begin
            n_q3 = recip_prod[Q441_SHIFT +: SIZE_W];
        end else begin
            n_q3 = r_x2[SIZE_W:1];
        end
    end

    // Stage four: add the padding byte; failed headers report zero.
    always_comb begin
        if (r_f3.status == ST_OK) begin
            n_size4 = r_q3 + SIZE_W'(r_f3.padding);
        end else begin
            n_size4 = '0;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload registers, loaded only with a live item.
    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_f2   <= i_fields;
            r_x2   <= n_x2;
            r_div2 <= i_ctl.div441;
        end
        if (rdy3 && r_v2) begin
            r_f3 <= r_f2;
            r_q3 <= n_q3;
        end
        if (rdy4 && r_v3) begin
            r_f4    <= r_f3;
            r_size4 <= n_size4;
        end
    end

    assign o_valid             = r_v4;
    assign o_result.fields     = r_f4;
    assign o_result.frame_size = r_size4;

endmodule

FILE: rtl/core/mpeg_audio_header_decoder_top.sv
// A new header word is accepted in every cycle as long as results are taken.
// The four register stages are header check and field unpack, the bitrate
// times rate-scale multiply, the reciprocal multiply that divides by 441
// for the 44.1 kHz rate family (or the halving for the other rates), and
// the padding add; each stage has its own valid bit, so a stalled result
// holds only the stages behind it.
//------------------------------------------------------------------------------
// mpeg_audio_header_decoder_top
// Audio frame header decoder: checks, field unpacking and frame size.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module mpeg_audio_header_decoder_top
    import mahd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mahd_in_if.sink    i_hdr,
    mahd_out_if.source o_res
);

    logic      s1_valid;
    logic      s1_ready;
    t_fields   s1_fields;
    t_size_ctl s1_ctl;
    t_result   res;
    logic      ok_shape;
    logic      err_clear;

    // Header checks and field decode.
    mahd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_hdr.valid),
        .i_word   (i_hdr.header_word),
        .o_ready  (i_hdr.ready),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_fields (s1_fields),
        .o_ctl    (s1_ctl)
    );

    // Frame size datapath and output register.
    mahd_size u_size (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s1_ready),
        .i_fields (s1_fields),
        .i_ctl    (s1_ctl),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (res)
    );

    // Result fields onto the output channel.
    assign o_res.status            = res.fields.status;
    assign o_res.version           = res.fields.version;
    assign o_res.layer             = res.fields.layer;
    assign o_res.crc_present       = res.fields.crc_present;
    assign o_res.kbps_index        = res.fields.kbps_index;
    assign o_res.sample_rate_index = res.fields.sample_rate_index;
    assign o_res.padding           = res.fields.padding;
    assign o_res.channel_mode      = res.fields.channel_mode;
    assign o_res.mode_extension    = res.fields.mode_extension;
    assign o_res.emphasis          = res.fields.emphasis;
    assign o_res.misc_flags        = res.fields.misc_flags;
    assign o_res.frame_size        = res.frame_size;

    // Shape of a good result and of a failed one.
    assign ok_shape  = (o_res.layer == 2'd2 || o_res.layer == 2'd3)
                       && o_res.frame_size != '0 && o_res.sample_rate_index <= 4'd8;
    assign err_clear = o_res.version == '0 && o_res.layer == '0
                       && o_res.kbps_index == '0 && o_res.frame_size == '0
                       && o_res.misc_flags == '0;

    // An accepted word always occupies the first stage in the next cycle.
    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_hdr.valid && i_hdr.ready, s1_valid)

    // A good header is layer II or III, has a nonzero frame length and a sample rate index up to 8.
    `ASSERT_IMPLY(a_ok_size, i_clk, i_rst_n, o_res.valid && o_res.status == ST_OK, ok_shape)

    // A failed header carries nothing but its status.
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_res.valid && o_res.status != ST_OK, err_clear)

endmodule

FILE: test/tb_mpeg_audio_header_decoder_top.sv
//------------------------------------------------------------------------------
// tb_mpeg_audio_header_decoder_top
// Drives MPEG audio header words into the decoder and compares every result
// item against a behavioral decoder. Directed corner words come first, then
// random words, most of them well-formed. Both handshake sides idle at random.
//------------------------------------------------------------------------------
module tb_mpeg_audio_header_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mahd_pkg::*;

    // Header version bit codes (bits 20..19).
    localparam logic [1:0] VB_MPEG1  = 2'b11;
    localparam logic [1:0] VB_MPEG2  = 2'b10;
    localparam logic [1:0] VB_MPEG25 = 2'b00;
    localparam logic [1:0] VB_RSV    = 2'b01;
    localparam logic [1:0] LB_LAYER2 = 2'b10;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 250;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PRINT_LIMIT   = 100;

    // Bitrate tables in kbit/s and the sampling rates in Hz.
    localparam int MP1_L2_KBPS [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                        128, 160, 192, 224, 256, 320, 384, 0};
    localparam int MP1_L3_KBPS [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
                                        112, 128, 160, 192, 224, 256, 320, 0};
    localparam int LSF_KBPS [16]    = '{0, 8, 16, 24, 32, 40, 48, 56,
                                        64, 80, 96, 112, 128, 144, 160, 0};
    localparam int RATE_HZ [9]      = '{44100, 48000, 32000, 22050, 24000,
                                        16000, 11025, 12000, 8000};

    typedef struct {
        logic [31:0] word;
        t_result     res;
    } t_decoded_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic calm;

    logic [31:0]   header_words_q[$];
    t_decoded_item decoded_q[$];
    int            mismatch_count;
    int            results_seen;
    int            stall_cycles;
    int            hold_left;

    mahd_in_if  hdr_if ();
    mahd_out_if res_if ();

    mpeg_audio_header_decoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_if),
        .o_res   (res_if)
    );

    // Clock generation, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decode one header word the way the block is meant to.
    function automatic t_result decode_header(logic [31:0] w);
        t_result  r;
        logic     lsf;
        int       layer_num;
        int       sri;
        int       kbps;
        int       denom;
        int       size_bytes;
        r = '0;
        lsf = !(w[20] && w[19]);
        layer_num = 4 - int'(w[18:17]);
        if (w[31:21] != 11'h7FF) begin
            r.fields.status = ST_NO_SYNC;
        end else if (w[20:19] == VB_RSV) begin
            r.fields.status = ST_RSV_VERSION;
        end else if (w[18:17] == LBITS_RSV) begin
            r.fields.status = ST_RSV_LAYER;
        end else if (w[15:12] == BRI_FREE || w[15:12] == BRI_BAD) begin
            r.fields.status = ST_BAD_BITRATE;
        end else if (w[11:10] == SR_RSV) begin
            r.fields.status = ST_BAD_RATE;
        end else if (w[18:17] == LBITS_LAYER1) begin
            r.fields.status = ST_LAYER_ONE;
        end else begin
            r.fields.status = ST_OK;
            if (w[20])
                r.fields.version = w[19] ? VER_MPEG1 : VER_MPEG2;
            else
                r.fields.version = VER_MPEG25;
            if (r.fields.version == VER_MPEG25)
                sri = 6 + int'(w[11:10]);
            else
                sri = int'(w[11:10]) + (lsf ? 3 : 0);
            if (lsf)
                kbps = LSF_KBPS[w[15:12]];
            else if (layer_num == 2)
                kbps = MP1_L2_KBPS[w[15:12]];
            else
                kbps = MP1_L3_KBPS[w[15:12]];
            denom = RATE_HZ[sri];
            // Layer III at the low sampling frequencies uses half the frame.
            if (layer_num == 3 && lsf)
                denom = denom * 2;
            size_bytes = kbps * 144000 / denom + int'(w[9]);
            r.fields.layer             = 2'(layer_num);
            r.fields.crc_present       = ~w[16];
            r.fields.kbps_index        = w[15:12];
            r.fields.sample_rate_index = 4'(sri);
            r.fields.padding           = w[9];
            r.fields.channel_mode      = w[7:6];
            r.fields.mode_extension    = w[5:4];
            r.fields.emphasis          = w[1:0];
            r.fields.misc_flags        = {w[8], w[3], w[2]};
            r.frame_size               = 12'(size_bytes);
        end
        return r;
    endfunction

    // Assemble a header word with a good sync field.
    function automatic logic [31:0] make_header(
        logic [1:0] ver_bits, logic [1:0] layer_bits, logic prot,
        logic [3:0] bri, logic [1:0] sr, logic pad, logic priv,
        logic [1:0] mode, logic [1:0] modext, logic copy, logic orig,
        logic [1:0] emph);
        return {11'h7FF, ver_bits, layer_bits, prot, bri, sr, pad, priv,
                mode, modext, copy, orig, emph};
    endfunction

    // Random header word: mostly well-formed, the rest noise and broken sync.
    function automatic logic [31:0] random_header();
        logic [31:0] w;
        int          pick;
        int          vsel;
        w = $urandom;
        pick = $urandom_range(0, 99);
        vsel = $urandom_range(0, 2);
        if (pick < 70) begin
            w[31:21] = 11'h7FF;
            w[20:19] = (vsel == 0) ? VB_MPEG1 : (vsel == 1) ? VB_MPEG2 : VB_MPEG25;
            w[18:17] = 2'($urandom_range(1, 3));
            w[15:12] = 4'($urandom_range(1, 14));
            w[11:10] = 2'($urandom_range(0, 2));
        end else if (pick < 85) begin
            w[31:21] = 11'h7FF;
        end else if (pick < 93) begin
            w = w;
        end else begin
            w[31:21] = 11'h7FF;
            w[21 + $urandom_range(0, 10)] = 1'b0;
        end
        return w;
    endfunction

    // Print one line per mismatch, up to a limit, and count all of them.
    task automatic report_mismatch(string text);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR: %s", text);
    endtask

    task automatic check_field(string name, logic [31:0] word,
                               logic [11:0] got, logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s for header %08h: got %0d, expected %0d",
                                      name, word, got, want));
    endtask

    // Driver: offer queued header words and record each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hdr_if.valid <= 1'b0;
        end else begin
            if (hdr_if.valid && hdr_if.ready)
                decoded_q.push_back('{hdr_if.header_word,
                                      decode_header(hdr_if.header_word)});
            if (!hdr_if.valid || hdr_if.ready) begin
                if (header_words_q.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                    hdr_if.valid       <= 1'b1;
                    hdr_if.header_word <= header_words_q.pop_front();
                end else begin
                    hdr_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result item with the oldest decoded word.
    always @(posedge i_clk) begin
        t_decoded_item d;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result item with no header pending, status %0d",
                                              res_if.status));
                end else begin
                    d = decoded_q.pop_front();
                    check_field("status", d.word, 12'(res_if.status),
                                12'(d.res.fields.status));
                    check_field("version", d.word, 12'(res_if.version),
                                12'(d.res.fields.version));
                    check_field("layer", d.word, 12'(res_if.layer),
                                12'(d.res.fields.layer));
                    check_field("crc_present", d.word, 12'(res_if.crc_present),
                                12'(d.res.fields.crc_present));
                    check_field("kbps_index", d.word, 12'(res_if.kbps_index),
                                12'(d.res.fields.kbps_index));
                    check_field("sample_rate_index", d.word, 12'(res_if.sample_rate_index),
                                12'(d.res.fields.sample_rate_index));
                    check_field("padding", d.word, 12'(res_if.padding),
                                12'(d.res.fields.padding));
                    check_field("channel_mode", d.word, 12'(res_if.channel_mode),
                                12'(d.res.fields.channel_mode));
                    check_field("mode_extension", d.word, 12'(res_if.mode_extension),
                                12'(d.res.fields.mode_extension));
                    check_field("emphasis", d.word, 12'(res_if.emphasis),
                                12'(d.res.fields.emphasis));
                    check_field("misc_flags", d.word, 12'(res_if.misc_flags),
                                12'(d.res.fields.misc_flags));
                    check_field("frame_size", d.word, res_if.frame_size, d.res.frame_size);
                end
            end
            // One long hold-off lets the pipeline fill and back up the input.
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else if (results_seen == HOLD_AT && res_if.valid && res_if.ready) begin
                hold_left    <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus sequencing and the end of the run.
    initial begin
        logic [1:0] vers [3];
        int         n;
        vers = '{VB_MPEG1, VB_MPEG2, VB_MPEG25};
        i_rst_n            = 1'b0;
        calm               = 1'b0;
        hdr_if.valid       = 1'b0;
        hdr_if.header_word = '0;
        res_if.ready       = 1'b0;
        mismatch_count     = 0;
        results_seen       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words: extremes, every failing check and its priority.
        header_words_q.push_back(32'h0000_0000);
        header_words_q.push_back(32'hFFFF_FFFF);
        header_words_q.push_back(make_header(VB_MPEG1, LB_LAYER2, 1'b1, 4'd9, 2'd0, 1'b0,
                                             1'b0, 2'd0, 2'd0, 1'b0, 1'b0, 2'd0)
                                 & ~32'h0020_0000);
        header_words_q.push_back(make_header(VB_RSV, LB_LAYER2, 1'b0, 4'd5, 2'd1, 1'b0,
                                             1'b0, 2'd1, 2'd0, 1'b0, 1'b0, 2'd0));
        header_words_q.push_back(make_header(VB_MPEG1, LBITS_RSV, 1'b0, 4'd5, 2'd1, 1'b0,
                                             1'b0, 2'd1, 2'd0, 1'b0, 1'b0, 2'd0));
        header_words_q.push_back(make_header(VB_MPEG1, LBITS_RSV, 1'b0, BRI_BAD, SR_RSV,
                                             1'b1, 1'b1, 2'd3, 2'd3, 1'b1, 1'b1, 2'd3));
        header_words_q.push_back(make_header(VB_MPEG2, LBITS_LAYER3, 1'b1, BRI_FREE, 2'd0,
                                             1'b0, 1'b0, 2'd0, 2'd0, 1'b0, 1'b0, 2'd0));
        header_words_q.push_back(make_header(VB_MPEG2, LBITS_LAYER3, 1'b1, BRI_BAD, 2'd0,
                                             1'b0, 1'b0, 2'd0, 2'd0, 1'b0, 1'b0, 2'd0));
        header_words_q.push_back(make_header(VB_MPEG25, LB_LAYER2, 1'b1, 4'd7, SR_RSV,
                                             1'b0, 1'b0, 2'd2, 2'd1, 1'b0, 1'b0, 2'd0));
        header_words_q.push_back(make_header(VB_MPEG1, LBITS_LAYER1, 1'b0, 4'd14, SR_RSV,
                                             1'b0, 1'b0, 2'd0, 2'd0, 1'b0, 1'b0, 2'd0));
        header_words_q.push_back(make_header(VB_MPEG1, LBITS_LAYER1, 1'b0, 4'd14, 2'd0,
                                             1'b1, 1'b1, 2'd3, 2'd3, 1'b1, 1'b1, 2'd3));
        // Every version with layers II and III at the largest bitrate, and layer III at the smallest.
        for (int v = 0; v < 3; v++) begin
            header_words_q.push_back(make_header(vers[v], LB_LAYER2, 1'b0, 4'd14, 2'(v),
                                                 1'b1, 1'b1, 2'd3, 2'd3, 1'b1, 1'b1, 2'd3));
            header_words_q.push_back(make_header(vers[v], LBITS_LAYER3, 1'b1, 4'd14, 2'd2,
                                                 1'b0, 1'b0, 2'd1, 2'd2, 1'b0, 1'b0, 2'd0));
            header_words_q.push_back(make_header(vers[v], LBITS_LAYER3, 1'b0, 4'd1, 2'd0,
                                                 1'b1, 1'b0, 2'd2, 2'd1, 1'b1, 1'b0, 2'd2));
        end
        header_words_q.push_back(make_header(VB_MPEG25, LB_LAYER2, 1'b1, 4'd14, 2'd2, 1'b1,
                                             1'b0, 2'd0, 2'd0, 1'b0, 1'b1, 2'd1));
        header_words_q.push_back(make_header(VB_MPEG1, LB_LAYER2, 1'b0, 4'd1, 2'd2, 1'b0,
                                             1'b1, 2'd3, 2'd0, 1'b1, 1'b0, 2'd2));

        // Random words with idling on both sides; the long hold-off falls here.
        n = RANDOM_ITEMS / 2;
        repeat (n) header_words_q.push_back(random_header());

        // The sender pauses until every pending result has been taken.
        while (header_words_q.size() != 0 || hdr_if.valid || decoded_q.size() != 0)
            @(negedge i_clk);

        // A stretch with no idling on either side.
        calm = 1'b1;
        repeat (RANDOM_ITEMS / 4) header_words_q.push_back(random_header());
        while (header_words_q.size() != 0)
            @(negedge i_clk);
        calm = 1'b0;

        repeat (RANDOM_ITEMS - n - RANDOM_ITEMS / 4) header_words_q.push_back(random_header());

        // Wait for the last results, then a few more cycles for stray items.
        while (header_words_q.size() != 0 || hdr_if.valid || decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
